// ===== rtl/vdi_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// vdi_pkg
// Shared types and constants for the vertex deduplication indexer: item
// structs, the key word held by each table cell, result kinds, the control
// bundle broadcast to the cell chain and the controller states.
// ----------------------------------------------------------------------------
package vdi_pkg;

    // Table geometry. The index and count widths follow from the depth.
    localparam int TABLE_DEPTH = 1024;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = IDX_W + 1;
    localparam int OUT_IDX_W   = 10;
    localparam int KEY_W       = 256;

    // One unindexed vertex as it arrives.
    typedef struct packed {
        logic        start_of_mesh;
        logic [31:0] pos_x;
        logic [31:0] pos_y;
        logic [31:0] pos_z;
        logic [31:0] tex_u;
        logic [31:0] tex_v;
        logic [31:0] norm_x;
        logic [31:0] norm_y;
        logic [31:0] norm_z;
    } t_in_item;

    // One result.
    typedef struct packed {
        logic [OUT_IDX_W-1:0] vertex_index;
        logic [1:0]           result_kind;
    } t_out_item;

    typedef logic [KEY_W-1:0] t_key;
    typedef logic [IDX_W-1:0] t_idx;

    // Result kinds.
    typedef enum logic [1:0] {
        KIND_MATCH = 2'd0,
        KIND_NEW   = 2'd1,
        KIND_FULL  = 2'd2
    } t_kind;

    // Control broadcast from the controller to every cell.
    typedef struct packed {
        logic load;
        logic wr_en;
        t_idx wr_idx;
    } t_cell_ctrl;

    // Controller states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_COMPARE,
        ST_SCAN
    } t_state;

    // Low bits of a table index as carried on the result port.
    function automatic logic [OUT_IDX_W-1:0] to_out_index(input t_idx idx);
        logic [IDX_W+OUT_IDX_W-1:0] ext;
        ext = {{OUT_IDX_W{1'b0}}, idx};
        return ext[OUT_IDX_W-1:0];
    endfunction

endpackage
`default_nettype wire

// ===== rtl/vertex_dedup_indexer_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// vertex_dedup_indexer_core
// Vertex deduplication for an index buffer, built as a chain of table cells.
// ----------------------------------------------------------------------------
// Usage:
//   A vertex transfer happens at a rising edge with start high and busy low.
//   The item holds start_of_mesh and eight raw 32-bit float patterns. Every
//   item gives exactly one result on o_result, marked by o_done for a single
//   cycle; the receiver must take it then, it cannot stall the block.
//   start_of_mesh empties the table before the vertex is looked up.
// Timing:
//   After the transfer, the compare state loads every cell's compare against the
//   query. The match flags then shift toward cell 0 one cell per cycle and
//   the controller inspects one entry per cycle. A match at index j is
//   found when the scan reaches entry j; a miss scans every stored vertex
//   (none for an empty table). o_done is high in the first cycle with busy
//   low, and the next transfer may be taken in that same cycle.
// Reset:
//   Synchronous, active low. The table comes out empty; no clearing pass is
//   needed because only entries below the stored count are ever inspected.
// ----------------------------------------------------------------------------
module vertex_dedup_indexer_core
    import vdi_pkg::*;
(
    input  wire           i_clk,
    input  wire           i_rst_n,
    input  wire           start,
    output logic          busy,
    input  wire t_in_item i_item,
    output t_out_item     o_result,
    output logic          o_done
);

    t_state     r_state, n_state;
    logic [CNT_W-1:0] r_count, n_count;
    t_idx       r_scan, n_scan;
    t_out_item  r_out, n_out;
    logic       r_done, n_done;
    t_key       r_key;
    t_cell_ctrl w_ctrl;
    logic       w_hit [TABLE_DEPTH+1];
    logic       w_scan_last;

    // Query key held for the whole search.
    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_key <= {i_item.pos_x, i_item.pos_y, i_item.pos_z, i_item.tex_u,
                      i_item.tex_v, i_item.norm_x, i_item.norm_y, i_item.norm_z};
        end
    end

    // Cell chain; the far end feeds a constant miss.
    assign w_hit[TABLE_DEPTH] = 1'b0;

    for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
        vdi_cell u_cell (
            .i_clk      (i_clk),
            .i_ctrl     (w_ctrl),
            .i_cell_idx (IDX_W'(g)),
            .i_key      (r_key),
            .i_hit_next (w_hit[g+1]),
            .o_hit      (w_hit[g])
        );
    end

    assign w_scan_last = ((CNT_W'(r_scan) + CNT_W'(1)) == r_count);

    // Next state, search control and result.
    always_comb begin
        n_state       = r_state;
        n_count       = r_count;
        n_scan        = r_scan;
        n_out         = r_out;
        n_done        = 1'b0;
        w_ctrl        = '0;
        w_ctrl.wr_idx = r_count[IDX_W-1:0];
        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_state = ST_COMPARE;
                    if (i_item.start_of_mesh) begin
                        n_count = '0;
                    end
                end
            end
            ST_COMPARE: begin
                w_ctrl.load = 1'b1;
                n_scan      = '0;
                if (r_count == '0) begin
                    // Empty table: append at index 0 without scanning.
                    w_ctrl.wr_en       = 1'b1;
                    n_count            = CNT_W'(1);
                    n_out.vertex_index = to_out_index('0);
                    n_out.result_kind  = KIND_NEW;
                    n_done             = 1'b1;
                    n_state            = ST_IDLE;
                end else begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (w_hit[0]) begin
                    n_out.vertex_index = to_out_index(r_scan);
                    n_out.result_kind  = KIND_MATCH;
                    n_done             = 1'b1;
                    n_state            = ST_IDLE;
                end else if (w_scan_last) begin
                    if (r_count == CNT_W'(TABLE_DEPTH)) begin
                        n_out.vertex_index = '0;
                        n_out.result_kind  = KIND_FULL;
                    end else begin
                        w_ctrl.wr_en       = 1'b1;
                        n_count            = r_count + CNT_W'(1);
                        n_out.vertex_index = to_out_index(r_count[IDX_W-1:0]);
                        n_out.result_kind  = KIND_NEW;
                    end
                    n_done  = 1'b1;
                    n_state = ST_IDLE;
                end else begin
                    n_scan = r_scan + IDX_W'(1);
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_done  <= n_done;
        end
    end

    // Scan position and result payload.
    always_ff @(posedge i_clk) begin
        r_scan <= n_scan;
        r_out  <= n_out;
    end

    assign busy     = (r_state != ST_IDLE);
    assign o_result = r_out;
    assign o_done   = r_done;

    // The stored count never exceeds the table depth.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(TABLE_DEPTH))
        else $error("stored count above table depth");

    // A dropped vertex is only reported with a full table.
    a_full_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_result.result_kind == KIND_FULL)) |->
            (r_count == CNT_W'(TABLE_DEPTH)))
        else $error("full result with room left");

    // The scan never inspects an entry at or beyond the stored count.
    a_scan_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> (CNT_W'(r_scan) < r_count))
        else $error("scan beyond stored entries");

    // A new vertex always grows the table by one.
    a_append_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_result.result_kind == KIND_NEW)) |->
            (r_count == $past(r_count) + CNT_W'(1)) || (r_count == CNT_W'(1)))
        else $error("append without count growth");

    // Accepting an item always starts a search.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted item did not start a search");

endmodule
`default_nettype wire

// ===== rtl/vdi_cell.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// vdi_cell
// One table entry of the deduplication chain. It stores one vertex key,
// compares it with the broadcast query and then passes match flags toward
// the head of the chain, one cell per cycle.
// ----------------------------------------------------------------------------
module vdi_cell
    import vdi_pkg::*;
(
    input  wire             i_clk,
    input  wire t_cell_ctrl i_ctrl,
    input  wire t_idx       i_cell_idx,
    input  wire t_key       i_key,
    input  wire             i_hit_next,
    output logic            o_hit
);

    t_key r_key;
    logic r_hit;

    // Store the query key when this cell is the append target.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.wr_en && (i_ctrl.wr_idx == i_cell_idx)) begin
            r_key <= i_key;
        end
    end

    // Capture the local compare on load, otherwise take the neighbor's flag.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_hit <= (r_key == i_key);
        end else begin
            r_hit <= i_hit_next;
        end
    end

    assign o_hit = r_hit;

endmodule
`default_nettype wire
